// File: sv/helicity_window_checker_pairer_macros.svh
`ifndef HELICITY_WINDOW_CHECKER_PAIRER_MACROS_SVH
`define HELICITY_WINDOW_CHECKER_PAIRER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HWCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HWCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/hwcp_pkg.sv
package hwcp_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 32;

    localparam logic [1:0] HEL_LEFT    = 2'd0;
    localparam logic [1:0] HEL_RIGHT   = 2'd1;
    localparam logic [1:0] HEL_UNKNOWN = 2'd2;
    localparam logic [1:0] HEL_INVALID = 2'd3;

    localparam logic [23:0] PRED_SEED       = 24'h000001;
    localparam logic [4:0]  GOOD_RUN_MAX    = 5'd25;
    localparam logic [4:0]  GOOD_RUN_TRUST  = 5'd24;
    localparam logic [7:0]  SLOT_WIN_START  = 8'd1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SYNCH_MID  = 3'd1,
        ST_SYNCH_SAME = 3'd2,
        ST_HEL_MID    = 3'd3,
        ST_HEL_SAME   = 3'd4,
        ST_HEL_WRONG  = 3'd5
    } t_seq_status;

    typedef enum logic [1:0] {
        PE_NONE     = 2'd0,
        PE_DROPPED  = 2'd1,
        PE_ALONE    = 2'd2,
        PE_OVERFLOW = 2'd3
    } t_pair_err;

    typedef struct packed {
        logic [31:0] event_number;
        logic [7:0]  time_slot;
        logic        pair_synch;
        logic [1:0]  helicity;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  sequence_status;
        logic        pair_made;
        logic [31:0] right_event;
        logic [31:0] left_event;
        logic [1:0]  pairing_error;
        logic        skipping_now;
    } t_out_item;

    typedef struct packed {
        logic       adv;
        logic       is_first;
        logic       slot_one;
        logic       synch;
        logic [1:0] hel;
        logic       seen;
    } t_step;

endpackage

// File: sv/hwcp_seq_check.sv
module hwcp_seq_check (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  hwcp_pkg::t_step        i_step,
    output hwcp_pkg::t_seq_status  o_status
);

    logic        r_cur_synch, n_cur_synch;
    logic [1:0]  r_cur_hel, n_cur_hel;
    logic        r_cur_seen, n_cur_seen;
    logic [23:0] r_shift, n_shift;
    logic [4:0]  r_good_cnt, n_good_cnt;

    logic pred_bit;
    logic trusted;
    logic mismatch;

    assign pred_bit = r_shift[23] ^ r_shift[22] ^ r_shift[21] ^ r_shift[16];
    assign trusted  = (r_good_cnt > hwcp_pkg::GOOD_RUN_TRUST);
    assign mismatch = (i_step.hel != {1'b0, pred_bit});

    always_comb begin
        n_cur_synch = r_cur_synch;
        n_cur_hel   = r_cur_hel;
        n_cur_seen  = r_cur_seen;
        n_shift     = r_shift;
        n_good_cnt  = r_good_cnt;
        o_status    = hwcp_pkg::ST_OK;
        if (i_step.slot_one) begin
            n_cur_synch = i_step.synch;
            n_cur_hel   = i_step.hel;
            n_cur_seen  = i_step.seen;
            if (r_cur_seen) begin
                if (i_step.synch == r_cur_synch) begin
                    o_status = hwcp_pkg::ST_SYNCH_SAME;
                end
                if (i_step.is_first) begin
                    n_shift = {r_shift[22:0], pred_bit};
                    if (r_good_cnt < hwcp_pkg::GOOD_RUN_MAX) begin
                        n_good_cnt = r_good_cnt + 5'd1;
                    end
                    if ((i_step.hel != hwcp_pkg::HEL_UNKNOWN) && mismatch) begin
                        n_shift = {r_shift[22:0], i_step.hel[0]};
                        if (trusted) begin
                            n_good_cnt = '0;
                        end
                    end
                    if (trusted && mismatch) begin
                        o_status = hwcp_pkg::ST_HEL_WRONG;
                    end
                end else if (i_step.hel == r_cur_hel) begin
                    o_status = hwcp_pkg::ST_HEL_SAME;
                end
            end
        end else if (r_cur_seen) begin
            if (i_step.synch != r_cur_synch) begin
                o_status = hwcp_pkg::ST_SYNCH_MID;
            end
            if (i_step.hel != r_cur_hel) begin
                o_status = hwcp_pkg::ST_HEL_MID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_synch <= 1'b0;
            r_cur_hel   <= hwcp_pkg::HEL_LEFT;
            r_cur_seen  <= 1'b0;
            r_shift     <= hwcp_pkg::PRED_SEED;
            r_good_cnt  <= '0;
        end else if (i_step.adv) begin
            r_cur_synch <= n_cur_synch;
            r_cur_hel   <= n_cur_hel;
            r_cur_seen  <= n_cur_seen;
            r_shift     <= n_shift;
            r_good_cnt  <= n_good_cnt;
        end
    end

endmodule

// File: sv/hwcp_pair_queue.sv
`include "helicity_window_checker_pairer_macros.svh"

module hwcp_pair_queue #(
    parameter int QUEUE_DEPTH = hwcp_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = hwcp_pkg::TAG_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hwcp_pkg::t_step       i_step,
    input  logic [TAG_BITS-1:0]   i_tag,
    output logic                  o_paired,
    output logic [TAG_BITS-1:0]   o_right,
    output logic [TAG_BITS-1:0]   o_left,
    output hwcp_pkg::t_pair_err   o_perr,
    output logic                  o_skipping
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = TAG_BITS + 2;
    localparam logic [FW-1:0] FULL     = FW'(QUEUE_DEPTH);
    localparam logic [FW:0]   DEPTH_X  = (FW + 1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rd;

    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_skip, n_skip;
    logic          r_last_paired;

    logic          we;
    logic [AW-1:0] wa;
    logic [EW-1:0] wd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] base_head;
    logic [FW-1:0] base_fill;
    logic          push;
    logic [FW:0]   tail_sum;
    logic [FW:0]   tail_wrap;
    logic          skip_now;

    assign wd = {i_tag, i_step.hel};

    always_comb begin
        skip_now  = (i_step.is_first && i_step.slot_one) ? 1'b0 : r_skip;
        n_skip    = skip_now;
        n_head    = r_head;
        n_fill    = r_fill;
        o_perr    = hwcp_pkg::PE_NONE;
        o_paired  = 1'b0;
        o_right   = '0;
        o_left    = '0;
        we        = 1'b0;
        push      = 1'b0;
        base_head = r_head;
        base_fill = r_fill;
        tail_sum  = '0;
        tail_wrap = '0;
        wa        = '0;
        if (!skip_now) begin
            if (i_step.is_first) begin
                push = 1'b1;
                if (r_last_paired && (r_fill != '0)) begin
                    o_perr    = hwcp_pkg::PE_DROPPED;
                    base_head = '0;
                    base_fill = '0;
                    if (!i_step.slot_one) begin
                        n_skip = 1'b1;
                        push   = 1'b0;
                    end
                end
                n_head = base_head;
                n_fill = base_fill;
                tail_sum  = (FW + 1)'(base_head) + (FW + 1)'(base_fill);
                tail_wrap = (tail_sum >= DEPTH_X) ? (tail_sum - DEPTH_X) : tail_sum;
                wa        = tail_wrap[AW-1:0];
                if (push) begin
                    if (base_fill == FULL) begin
                        o_perr = hwcp_pkg::PE_OVERFLOW;
                    end else begin
                        we     = 1'b1;
                        n_fill = base_fill + FW'(1);
                    end
                end
            end else if (r_fill != '0) begin
                o_paired = 1'b1;
                if (r_rd[1:0] == hwcp_pkg::HEL_RIGHT) begin
                    o_right = r_rd[EW-1:2];
                    o_left  = i_tag;
                end else begin
                    o_right = i_tag;
                    o_left  = r_rd[EW-1:2];
                end
                n_head = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
                n_fill = r_fill - FW'(1);
            end else begin
                o_perr = hwcp_pkg::PE_ALONE;
                n_skip = 1'b1;
            end
        end
    end

    assign o_skipping = n_skip;
    assign rd_addr    = i_step.adv ? n_head : r_head;

    always_ff @(posedge i_clk) begin
        if (i_step.adv && we) begin
            mem[wa] <= wd;
        end
        if (i_step.adv && we && (wa == rd_addr)) begin
            r_rd <= wd;
        end else begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_fill        <= '0;
            r_skip        <= 1'b1;
            r_last_paired <= 1'b0;
        end else if (i_step.adv) begin
            r_head        <= n_head;
            r_fill        <= n_fill;
            r_skip        <= n_skip;
            r_last_paired <= o_paired;
        end
    end

    `HWCP_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FULL, "queue fill beyond depth")
    `HWCP_ASSERT_NEXT(a_overflow_hold, i_clk, i_rst_n, i_step.adv && (o_perr == hwcp_pkg::PE_OVERFLOW), $stable(r_fill) && $stable(r_head), "overflow changed the queue")
    `HWCP_ASSERT_NEXT(a_alone_skip, i_clk, i_rst_n, i_step.adv && (o_perr == hwcp_pkg::PE_ALONE), r_skip && (r_fill == '0), "unpartnered second did not start skipping")
    `HWCP_ASSERT_NOW(a_pair_clean, i_clk, i_rst_n, o_paired, (o_perr == hwcp_pkg::PE_NONE) && !i_step.is_first, "pair made with an error")

endmodule

// File: sv/helicity_window_checker_pairer.sv
// Helicity window checker and pairer.
// Input channel: i_in_valid / o_in_stall carry one event transaction
// (tag, time slot, pair synch, helicity). Output channel: o_out_valid /
// i_out_stall carry one result transaction per event: sequence status,
// pair made with right and left tags, pairing error and skipping flag.
// A transaction moves at a rising edge with valid high and stall low.
// Configuration: i_cfg_valid / o_cfg_ready write first_pair_synch; the port
// is always ready, and the user must see that it is written only while no
// event is in flight; the block does not enforce this. An event accepted
// into the input register passes combinationally through the window checks,
// LFSR step and queue push or pop into the result register, offered from
// then on. One event per cycle while the receiver does not stall. The queue
// head is held in a registered read port refreshed on every step.
// When the receiver stalls the result register holds and the input register
// holds one more event; o_in_stall rises only when both are full.
// Reset (synchronous, active low) empties both stages and the queue, seeds
// the predictor with 1, clears the good-run count and starts in skipping.
module helicity_window_checker_pairer #(
    parameter int QUEUE_DEPTH = hwcp_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = hwcp_pkg::TAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hwcp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hwcp_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    logic                r_in_vld;
    hwcp_pkg::t_in_item  r_in;
    logic                r_out_vld;
    hwcp_pkg::t_out_item r_out, n_out;
    logic                r_first_synch;

    logic                advance;
    logic [63:0]         tag_ext;
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          hel;
    hwcp_pkg::t_step     step;

    hwcp_pkg::t_seq_status status;
    logic                  paired;
    logic [TAG_BITS-1:0]   right_tag;
    logic [TAG_BITS-1:0]   left_tag;
    hwcp_pkg::t_pair_err   perr;
    logic                  skipping;
    logic [63:0]           right_ext;
    logic [63:0]           left_ext;

    assign advance     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !advance;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    assign tag_ext = {32'd0, r_in.event_number};
    assign tag     = tag_ext[TAG_BITS-1:0];
    assign hel     = (r_in.helicity == hwcp_pkg::HEL_INVALID) ? hwcp_pkg::HEL_UNKNOWN
                                                               : r_in.helicity;

    always_comb begin
        step.adv      = advance;
        step.is_first = (r_in.pair_synch == r_first_synch);
        step.slot_one = (r_in.time_slot == hwcp_pkg::SLOT_WIN_START);
        step.synch    = r_in.pair_synch;
        step.hel      = hel;
        step.seen     = (tag != '0);
    end

    hwcp_seq_check u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_status (status)
    );

    hwcp_pair_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_pair (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_tag      (tag),
        .o_paired   (paired),
        .o_right    (right_tag),
        .o_left     (left_tag),
        .o_perr     (perr),
        .o_skipping (skipping)
    );

    assign right_ext = 64'(right_tag);
    assign left_ext  = 64'(left_tag);

    always_comb begin
        n_out.sequence_status = status;
        n_out.pair_made       = paired;
        n_out.right_event     = right_ext[31:0];
        n_out.left_event      = left_ext[31:0];
        n_out.pairing_error   = perr;
        n_out.skipping_now    = skipping;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_first_synch <= 1'b1;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_first_synch <= i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// File: bench/tb_helicity_window_checker_pairer.sv
module tb_helicity_window_checker_pairer;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  hel;
        logic [31:0] tag;
    } t_held_first;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    hwcp_pkg::t_in_item  i_in_item   = '0;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                i_cfg_data  = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    hwcp_pkg::t_out_item o_out_item;
    logic                o_cfg_ready;

    helicity_window_checker_pairer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // window tracking and pairing state, at its reset values
    logic        first_synch_cfg = 1'b1;
    logic        cur_synch       = 1'b0;
    logic [1:0]  cur_hel         = 2'd0;
    logic        cur_seen        = 1'b0;
    logic        last_synch      = 1'b0;
    logic [1:0]  last_hel        = 2'd0;
    logic        last_seen       = 1'b0;
    logic [23:0] hel_lfsr        = hwcp_pkg::PRED_SEED;
    logic [4:0]  good_run        = 5'd0;
    logic        skip_mode       = 1'b1;
    logic        paired_prev     = 1'b0;
    t_held_first held_firsts[$];

    hwcp_pkg::t_in_item  pending_events[$];
    hwcp_pkg::t_out_item expected_results[$];
    logic [23:0] gen_lfsr;
    int          events_added   = 0;
    int          mismatches     = 0;
    int          results_seen   = 0;
    int          pairs_seen     = 0;
    int          hel_wrong_seen = 0;
    int          overflow_seen  = 0;
    int          fault_seen     = 0;
    int          settings_used  = 1;
    int          burst_left     = 0;
    int          gap_left       = 0;
    int          stall_left     = 0;
    int          stall_style    = 0;
    int          stall_phase    = 0;

    function automatic hwcp_pkg::t_out_item predict_event(hwcp_pkg::t_in_item ev);
        hwcp_pkg::t_out_item res;
        t_held_first         head;
        t_held_first         entry;
        logic [1:0]          hel;
        logic                first_win;
        logic                nb;
        logic                trusted;
        logic                push_it;
        res = '0;
        hel = (ev.helicity == hwcp_pkg::HEL_INVALID) ? hwcp_pkg::HEL_UNKNOWN : ev.helicity;
        first_win = (ev.pair_synch == first_synch_cfg);
        res.sequence_status = hwcp_pkg::ST_OK;
        if (ev.time_slot == hwcp_pkg::SLOT_WIN_START) begin
            last_synch = cur_synch;
            last_hel   = cur_hel;
            last_seen  = cur_seen;
            cur_synch  = ev.pair_synch;
            cur_hel    = hel;
            cur_seen   = (ev.event_number != 32'd0);
            if (last_seen) begin
                if (ev.pair_synch == last_synch)
                    res.sequence_status = hwcp_pkg::ST_SYNCH_SAME;
                if (first_win) begin
                    nb = hel_lfsr[23] ^ hel_lfsr[22] ^ hel_lfsr[21] ^ hel_lfsr[16];
                    hel_lfsr = {hel_lfsr[22:0], nb};
                    trusted = (good_run > hwcp_pkg::GOOD_RUN_TRUST);
                    if (good_run < hwcp_pkg::GOOD_RUN_MAX)
                        good_run = good_run + 5'd1;
                    if (hel != hwcp_pkg::HEL_UNKNOWN && hel[0] != nb) begin
                        hel_lfsr[0] = hel[0];
                        if (trusted)
                            good_run = 5'd0;
                    end
                    if (trusted && hel != {1'b0, nb})
                        res.sequence_status = hwcp_pkg::ST_HEL_WRONG;
                end else if (hel == last_hel) begin
                    res.sequence_status = hwcp_pkg::ST_HEL_SAME;
                end
            end
        end else if (cur_seen) begin
            if (ev.pair_synch != cur_synch)
                res.sequence_status = hwcp_pkg::ST_SYNCH_MID;
            if (hel != cur_hel)
                res.sequence_status = hwcp_pkg::ST_HEL_MID;
        end

        if (first_win && ev.time_slot == hwcp_pkg::SLOT_WIN_START)
            skip_mode = 1'b0;
        if (!skip_mode) begin
            if (first_win) begin
                push_it = 1'b1;
                if (paired_prev && held_firsts.size() > 0) begin
                    res.pairing_error = hwcp_pkg::PE_DROPPED;
                    held_firsts.delete();
                    if (ev.time_slot != hwcp_pkg::SLOT_WIN_START) begin
                        skip_mode = 1'b1;
                        push_it = 1'b0;
                    end
                end
                if (push_it) begin
                    if (held_firsts.size() >= hwcp_pkg::QUEUE_DEPTH_DEF) begin
                        res.pairing_error = hwcp_pkg::PE_OVERFLOW;
                    end else begin
                        entry.hel = hel;
                        entry.tag = ev.event_number;
                        held_firsts.insert(held_firsts.size(), entry);
                    end
                end
            end else if (held_firsts.size() > 0) begin
                head = held_firsts[0];
                held_firsts.delete(0);
                if (head.hel == hwcp_pkg::HEL_RIGHT) begin
                    res.right_event = head.tag;
                    res.left_event  = ev.event_number;
                end else begin
                    res.right_event = ev.event_number;
                    res.left_event  = head.tag;
                end
                res.pair_made = 1'b1;
            end else begin
                res.pairing_error = hwcp_pkg::PE_ALONE;
                skip_mode = 1'b1;
            end
        end
        paired_prev = res.pair_made;
        res.skipping_now = skip_mode;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic logic [31:0] rand_tag();
        return ($urandom_range(0, 63) == 0) ? 32'd0 : 32'($urandom);
    endfunction

    task automatic add_event(input logic [31:0] tag, input logic [7:0] slot,
                             input logic synch, input logic [1:0] hel);
        hwcp_pkg::t_in_item ev;
        ev.event_number = tag;
        ev.time_slot    = slot;
        ev.pair_synch   = synch;
        ev.helicity     = hel;
        pending_events.insert(pending_events.size(), ev);
        events_added++;
    endtask

    task automatic add_window(input logic synch, input logic [1:0] hel, input int count,
                              input bit upset);
        int         fault_at;
        logic [7:0] slot;
        fault_at = upset ? $urandom_range(1, count) : -1;
        for (int i = 0; i < count; i++) begin
            if (i == 0)
                slot = hwcp_pkg::SLOT_WIN_START;
            else if ($urandom_range(0, 9) == 0)
                slot = 8'd0;
            else
                slot = 8'($urandom_range(2, 255));
            if (i != fault_at)
                add_event(rand_tag(), slot, synch, hel);
            else if ($urandom_range(0, 1))
                add_event(rand_tag(), slot, !synch, hel);
            else
                add_event(rand_tag(), slot, synch, hel ^ 2'($urandom_range(1, 3)));
        end
    endtask

    task automatic add_pair(input bit overflow);
        int         pick;
        int         n1;
        int         n2;
        logic       nb;
        logic [1:0] h1;
        logic [1:0] h2;
        pick = overflow ? 100 : $urandom_range(0, 99);
        if (pick < 4) begin
            add_event($urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      2'($urandom_range(0, 3)));
            return;
        end
        nb = gen_lfsr[23] ^ gen_lfsr[22] ^ gen_lfsr[21] ^ gen_lfsr[16];
        // flip the bit and keep it, so the stream stays in step after the fault
        if (pick < 8)
            nb = ~nb;
        gen_lfsr = {gen_lfsr[22:0], nb};
        h1 = {1'b0, nb};
        h2 = {1'b0, ~nb};
        if (pick >= 8 && pick < 12)
            h1 = $urandom_range(0, 1) ? hwcp_pkg::HEL_UNKNOWN : hwcp_pkg::HEL_INVALID;
        if (pick >= 12 && pick < 15)
            h2 = h1;
        n1 = overflow ? $urandom_range(hwcp_pkg::QUEUE_DEPTH_DEF + 1,
                                       hwcp_pkg::QUEUE_DEPTH_DEF + 2)
                      : $urandom_range(1, 5);
        n2 = n1;
        if (pick >= 15 && pick < 19)
            n2 = n1 - 1;
        else if (pick >= 19 && pick < 22)
            n2 = n1 + 1;
        else if (pick >= 22 && pick < 25)
            n2 = 0;
        add_window(first_synch_cfg, h1, n1, pick >= 25 && pick < 28);
        add_window(!first_synch_cfg, h2, n2, pick >= 28 && pick < 31);
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_first_synch(input logic value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        first_synch_cfg = value;
        settings_used++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                expected_results.insert(expected_results.size(), predict_event(i_in_item));
                pending_events.delete(0);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_item  <= pending_events[0];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                             : $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                           : $urandom_range(0, 3);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(50, 300);
        end
        stall_left--;
        stall_phase++;
        case (stall_style)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ((stall_phase % 9) < 4);
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        hwcp_pkg::t_out_item want;
        hwcp_pkg::t_out_item got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_item;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with no event outstanding, expected none, actual %0h",
                         $time, got);
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                check_field("sequence_status", 32'(want.sequence_status),
                            32'(got.sequence_status));
                check_field("pair_made", 32'(want.pair_made), 32'(got.pair_made));
                check_field("right_event", want.right_event, got.right_event);
                check_field("left_event", want.left_event, got.left_event);
                check_field("pairing_error", 32'(want.pairing_error),
                            32'(got.pairing_error));
                check_field("skipping_now", 32'(want.skipping_now), 32'(got.skipping_now));
                results_seen++;
                pairs_seen += int'(want.pair_made);
                if (want.sequence_status == hwcp_pkg::ST_HEL_WRONG)
                    hel_wrong_seen++;
                if (want.pairing_error == hwcp_pkg::PE_OVERFLOW)
                    overflow_seen++;
                else if (want.pairing_error != hwcp_pkg::PE_NONE)
                    fault_seen++;
            end
        end
    end

    initial begin
        int   phase_start;
        logic plan[4];
        plan = '{1'b0, 1'b1, 1'b0, 1'b1};
        gen_lfsr = 24'($urandom_range(1, 24'hFFFFFF));
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_event(32'hFFFFFFFF, hwcp_pkg::SLOT_WIN_START, 1'b1, hwcp_pkg::HEL_RIGHT);
        add_event(32'd0,        8'd2,                     1'b1, hwcp_pkg::HEL_RIGHT);
        add_event(32'd1,        8'd255,                   1'b1, hwcp_pkg::HEL_RIGHT);
        add_event(32'h80000000, hwcp_pkg::SLOT_WIN_START, 1'b0, hwcp_pkg::HEL_LEFT);
        add_event(32'd7,        8'd0,                     1'b0, hwcp_pkg::HEL_LEFT);
        add_event(32'd8,        8'd3,                     1'b1, hwcp_pkg::HEL_LEFT);
        add_event(32'd9,        8'd4,                     1'b0, hwcp_pkg::HEL_LEFT);
        add_event(32'd10,       hwcp_pkg::SLOT_WIN_START, 1'b1, hwcp_pkg::HEL_INVALID);
        add_event(32'd11,       8'd2,                     1'b1, hwcp_pkg::HEL_UNKNOWN);
        add_event(32'd12,       hwcp_pkg::SLOT_WIN_START, 1'b0, hwcp_pkg::HEL_RIGHT);
        add_event(32'd13,       8'd5,                     1'b0, hwcp_pkg::HEL_LEFT);
        add_event(32'd14,       8'd6,                     1'b0, hwcp_pkg::HEL_RIGHT);
        add_event(32'd15,       hwcp_pkg::SLOT_WIN_START, 1'b0, hwcp_pkg::HEL_LEFT);
        add_event(32'd16,       hwcp_pkg::SLOT_WIN_START, 1'b1, hwcp_pkg::HEL_RIGHT);
        add_event(32'd17,       8'd2,                     1'b1, hwcp_pkg::HEL_RIGHT);
        add_event(32'd0,        hwcp_pkg::SLOT_WIN_START, 1'b0, hwcp_pkg::HEL_RIGHT);
        add_event(32'd18,       8'd2,                     1'b0, hwcp_pkg::HEL_RIGHT);
        add_event(32'd19,       hwcp_pkg::SLOT_WIN_START, 1'b1, hwcp_pkg::HEL_LEFT);
        add_event(32'd20,       hwcp_pkg::SLOT_WIN_START, 1'b0, hwcp_pkg::HEL_RIGHT);
        add_event(32'd21,       hwcp_pkg::SLOT_WIN_START, 1'b1, hwcp_pkg::HEL_RIGHT);
        wait_idle();

        foreach (plan[p]) begin
            write_first_synch(plan[p]);
            phase_start = events_added;
            add_pair(1'b1);
            while (events_added - phase_start < 310)
                add_pair(1'b0);
            wait_idle();
        end

        $display("Checked %0d results from %0d events over %0d first-pair synch settings",
                 results_seen, events_added, settings_used);
        $display("Saw %0d pairs, %0d helicity faults, %0d overflows, %0d other pairing faults",
                 pairs_seen, hel_wrong_seen, overflow_seen, fault_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
